// File: design/bffa_pkg.sv
// Package for the bitmap first-free allocator.
// Pool sizes, derived widths, command and status codes, control types.
// No dependencies.
package bffa_pkg;

  localparam int INODE_POOL_SIZE = 128;
  localparam int BLOCK_POOL_SIZE = 1024;
  localparam int MAP_WORD_BITS   = 32;   // power of two

  localparam int INODE_WORDS = (INODE_POOL_SIZE + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int BLOCK_WORDS = (BLOCK_POOL_SIZE + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int TOTAL_WORDS = INODE_WORDS + BLOCK_WORDS;
  localparam int MAX_WORDS   = (INODE_WORDS > BLOCK_WORDS) ? INODE_WORDS : BLOCK_WORDS;

  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 11;

  localparam int BIT_W  = $clog2(MAP_WORD_BITS);
  localparam int WIDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int WCNT_W = $clog2(MAX_WORDS + 1);
  localparam int ADDR_W = $clog2(TOTAL_WORDS);
  localparam int ICNT_W = $clog2(INODE_POOL_SIZE + 1);
  localparam int BCNT_W = $clog2(BLOCK_POOL_SIZE + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_SET    = 2'd1,
    CMD_TOGGLE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic range_err;
    logic done;
    logic out_free;
  } stat_t;

  // Bits of the last map word that lie beyond the pool: treated as taken.
  function automatic logic [MAP_WORD_BITS-1:0] tail_mask(input int size, input int words);
    logic [MAP_WORD_BITS-1:0] m;
    m = '0;
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      if ((words - 1) * MAP_WORD_BITS + b >= size) m[b] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [MAP_WORD_BITS-1:0] INODE_TAIL = tail_mask(INODE_POOL_SIZE, INODE_WORDS);
  localparam logic [MAP_WORD_BITS-1:0] BLOCK_TAIL = tail_mask(BLOCK_POOL_SIZE, BLOCK_WORDS);

endpackage

// File: design/bffa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bffa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// File: design/bffa_datapath.sv
// Datapath: request registers, word scan, bitmap RAM with word valid bits,
// free counters and the output register. Uses bffa_pkg and bffa_ram.
module bffa_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  bffa_pkg::ctrl_t               ctrl,
  output bffa_pkg::stat_t               stat,
  input  logic [bffa_pkg::CMD_W-1:0]    command,
  input  logic                          pool,
  input  logic [bffa_pkg::INDEX_W-1:0]  index,
  input  logic                          bit_to_write,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bffa_pkg::STATUS_W-1:0] status,
  output logic [bffa_pkg::INDEX_W-1:0]  granted_index,
  output logic                          bit_value,
  output logic [bffa_pkg::FREE_W-1:0]   free_count
);
  import bffa_pkg::*;

  cmd_t                   req_cmd;
  logic                   req_pool;
  logic [INDEX_W-1:0]     req_index;
  logic                   req_bit;
  logic [WCNT_W-1:0]      rd_word;
  logic [WIDX_W-1:0]      last_word;
  logic                   chk_valid;
  logic [WIDX_W-1:0]      chk_word;
  logic                   vld_q;
  logic [TOTAL_WORDS-1:0] word_vld;
  logic [ICNT_W-1:0]      icnt, icnt_next;
  logic [BCNT_W-1:0]      bcnt, bcnt_next;

  status_t                res_status;
  logic [INDEX_W-1:0]     res_granted;
  logic                   res_bit;
  logic [FREE_W-1:0]      res_count;

  cmd_t                   cmd_in;
  logic                   range_err;
  logic [WIDX_W-1:0]      start_word;
  logic                   issue_ok;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      chk_addr;
  logic [MAP_WORD_BITS-1:0] rd_data;
  logic [MAP_WORD_BITS-1:0] word_data;
  logic [MAP_WORD_BITS-1:0] occ;
  logic [MAP_WORD_BITS-1:0] wr_data;
  logic                   found;
  logic [BIT_W-1:0]       find_pos;
  logic [BIT_W-1:0]       bit_sel;
  logic [BIT_W-1:0]       sel_pos;
  logic                   new_bit;
  logic                   sel_val;
  logic                   is_alloc;
  logic                   hit;
  logic                   is_last;
  logic                   done_act;
  logic                   wr_en;
  logic                   dec;

  assign cmd_in = cmd_t'(command);

  always_comb begin
    range_err = 1'b0;
    if (cmd_in != CMD_ALLOC) begin
      if (pool) range_err = {1'b0, index} >= FREE_W'(BLOCK_POOL_SIZE);
      else      range_err = {1'b0, index} >= FREE_W'(INODE_POOL_SIZE);
    end
  end

  assign start_word = (cmd_in == CMD_ALLOC) ? '0 : WIDX_W'(index >> BIT_W);
  assign issue_ok   = rd_word <= WCNT_W'(last_word);
  assign rd_en      = ctrl.scan && issue_ok;
  assign rd_addr    = req_pool ? ADDR_W'(INODE_WORDS) + ADDR_W'(rd_word) : ADDR_W'(rd_word);
  assign chk_addr   = req_pool ? ADDR_W'(INODE_WORDS) + ADDR_W'(chk_word) : ADDR_W'(chk_word);

  // Words never written read as all clear.
  assign word_data = vld_q ? rd_data : '0;
  assign is_last   = chk_word == last_word;
  assign is_alloc  = req_cmd == CMD_ALLOC;
  assign occ       = word_data | (is_last ? (req_pool ? BLOCK_TAIL : INODE_TAIL) : '0);

  always_comb begin
    found    = 1'b0;
    find_pos = '0;
    for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
      if (!occ[b]) begin
        found    = 1'b1;
        find_pos = BIT_W'(b);
      end
    end
  end

  assign bit_sel = req_index[BIT_W-1:0];

  always_comb begin
    case (req_cmd)
      CMD_SET:    new_bit = req_bit;
      CMD_TOGGLE: new_bit = ~word_data[bit_sel];
      default:    new_bit = word_data[bit_sel];
    endcase
  end

  assign sel_pos  = is_alloc ? find_pos : bit_sel;
  assign sel_val  = is_alloc ? 1'b1 : new_bit;
  assign hit      = is_alloc ? found : 1'b1;
  assign done_act = ctrl.scan && chk_valid && (hit || is_last);
  assign wr_en    = done_act && hit && (req_cmd != CMD_READ);

  always_comb begin
    wr_data          = word_data;
    wr_data[sel_pos] = sel_val;
  end

  assign dec = done_act && is_alloc && found;

  always_comb begin
    icnt_next = icnt;
    bcnt_next = bcnt;
    if (dec && !req_pool && icnt != '0) icnt_next = icnt - 1'b1;
    if (dec && req_pool && bcnt != '0)  bcnt_next = bcnt - 1'b1;
  end

  bffa_ram #(
    .WIDTH(MAP_WORD_BITS),
    .DEPTH(TOTAL_WORDS)
  ) u_map_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(chk_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      word_vld  <= '0;
      icnt      <= ICNT_W'(INODE_POOL_SIZE);
      bcnt      <= BCNT_W'(BLOCK_POOL_SIZE);
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      icnt <= icnt_next;
      bcnt <= bcnt_next;
      if (wr_en) word_vld[chk_addr] <= 1'b1;
      if (ctrl.accept)    chk_valid <= 1'b0;
      else if (ctrl.scan) chk_valid <= rd_en;
      if (ctrl.out_load)  out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      req_cmd   <= cmd_in;
      req_pool  <= pool;
      req_index <= index;
      req_bit   <= bit_to_write;
      rd_word   <= WCNT_W'(start_word);
      if (cmd_in == CMD_ALLOC)
        last_word <= pool ? WIDX_W'(BLOCK_WORDS - 1) : WIDX_W'(INODE_WORDS - 1);
      else
        last_word <= start_word;
      if (range_err) begin
        res_status  <= ST_RANGE;
        res_granted <= '0;
        res_bit     <= 1'b0;
        res_count   <= pool ? FREE_W'(bcnt) : FREE_W'(icnt);
      end
    end
    if (rd_en) begin
      rd_word  <= rd_word + 1'b1;
      chk_word <= WIDX_W'(rd_word);
      vld_q    <= word_vld[rd_addr];
    end
    if (done_act) begin
      res_status  <= status_t'(hit ? ST_OK : ST_NO_FREE);
      res_granted <= (hit && is_alloc) ?
                     (INDEX_W'(chk_word) << BIT_W) | INDEX_W'(find_pos) : '0;
      res_bit     <= hit ? sel_val : 1'b0;
      res_count   <= req_pool ? FREE_W'(bcnt_next) : FREE_W'(icnt_next);
    end
    if (ctrl.out_load) begin
      status        <= res_status;
      granted_index <= res_granted;
      bit_value     <= res_bit;
      free_count    <= res_count;
    end
  end

  assign stat.range_err = range_err;
  assign stat.done      = chk_valid && (hit || is_last);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

// File: design/bffa_controller.sv
// Controller state machine: accept, word scan, hand-off to output register.
// Uses bffa_pkg.
module bffa_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bffa_pkg::stat_t stat,
  output bffa_pkg::ctrl_t ctrl
);
  import bffa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = stat.range_err ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        if (stat.done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ctrl.accept   = 1'b0;
    ctrl.scan     = 1'b0;
    ctrl.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        ctrl.accept = in_valid;
      end
      S_SCAN: begin
        ctrl.scan = 1'b1;
      end
      S_FINISH: begin
        ctrl.out_load = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

// File: design/bitmap_first_free_allocator_top.sv
// Bitmap first-free allocator, top level.
// Depends on bffa_pkg, bffa_controller, bffa_datapath (which holds bffa_ram).
//
// One transaction at a time. Allocate reads the pool's bitmap one word per cycle
// from a single RAM read port and stops at the first word with a clear bit; the
// block pool has 32 words and the inode pool 4. Set, toggle and read read only
// the addressed word; an index outside the pool is answered without a read. The
// result sits in an output register, so the next transaction is taken while it
// waits. Both maps read as clear after reset with no clearing pass.
module bitmap_first_free_allocator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bffa_pkg::CMD_W-1:0]    command,
  input  logic                          pool,
  input  logic [bffa_pkg::INDEX_W-1:0]  index,
  input  logic                          bit_to_write,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bffa_pkg::STATUS_W-1:0] status,
  output logic [bffa_pkg::INDEX_W-1:0]  granted_index,
  output logic                          bit_value,
  output logic [bffa_pkg::FREE_W-1:0]   free_count
);
  import bffa_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  bffa_controller u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  bffa_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .command      (command),
    .pool         (pool),
    .index        (index),
    .bit_to_write (bit_to_write),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .granted_index(granted_index),
    .bit_value    (bit_value),
    .free_count   (free_count)
  );

endmodule

// File: design/bffa_checker.sv
// Port-level checks for the bitmap first-free allocator, bound to the top.
// Uses bffa_pkg.
module bffa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [bffa_pkg::CMD_W-1:0]    command,
  input logic                          pool,
  input logic [bffa_pkg::INDEX_W-1:0]  index,
  input logic                          bit_to_write,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bffa_pkg::STATUS_W-1:0] status,
  input logic [bffa_pkg::INDEX_W-1:0]  granted_index,
  input logic                          bit_value,
  input logic [bffa_pkg::FREE_W-1:0]   free_count
);
  import bffa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
    $stable(granted_index) && $stable(bit_value) && $stable(free_count))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while one is in progress");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_FREE || status == ST_RANGE) |->
    granted_index == '0 && !bit_value)
    else $error("failed transaction carries an index or bit");

  a_grant_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK && granted_index != '0 |-> bit_value)
    else $error("granted entry not shown as taken");

endmodule

bind bitmap_first_free_allocator_top bffa_checker u_bffa_checker (.*);
